// File: hw/rtl/dpms_pkg.sv
// ----------------------------------------------------------------------------
// dpms_pkg
// Types and constants for the door position motor sequencer: door states,
// motor actions, event codes and the configuration register map.
// ----------------------------------------------------------------------------
package dpms_pkg;

  localparam int CFG_REGS       = 8;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 8;

  typedef logic [CFG_DATA_BITS-1:0] cfg_word_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CLOSED_LOW  = 3'd0,
    REG_CLOSED_HIGH = 3'd1,
    REG_HALF_LOW    = 3'd2,
    REG_HALF_HIGH   = 3'd3,
    REG_OPEN_LOW    = 3'd4,
    REG_OPEN_HIGH   = 3'd5,
    REG_DETECT_LOW  = 3'd6,
    REG_DETECT_HIGH = 3'd7
  } reg_index_t;

  localparam cfg_word_t CFG_RESET [CFG_REGS] = '{
    8'd32, 8'd34, 8'd93, 8'd96, 8'd142, 8'd143, 8'd138, 8'd140
  };

  typedef enum logic [1:0] {
    OP_OPEN       = 2'd0,
    OP_SAMPLE     = 2'd1,
    OP_FULL_CLOSE = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_UNKNOWN = 3'd0,
    ST_CLOSED  = 3'd1,
    ST_HALF    = 3'd2,
    ST_OPENING = 3'd3,
    ST_OPEN    = 3'd4,
    ST_DETECT  = 3'd5,
    ST_HOME    = 3'd6
  } door_state_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_FWD  = 2'd1,
    ACT_REV  = 2'd2,
    ACT_STOP = 2'd3
  } action_t;

  typedef struct packed {
    door_state_t door_state;
    action_t     motor_action;
    logic        full_close_busy;
  } result_t;

endpackage

// File: hw/rtl/door_position_motor_sequencer.sv
// ----------------------------------------------------------------------------
// door_position_motor_sequencer
// Door state tracking and stepper command sequencing from open, sensor
// sample and full-close events, with configurable inclusive sensor windows.
// ----------------------------------------------------------------------------
// each input beat's result is registered into the two-entry output buffer
// throughput: one beat per cycle while in_ready is high, set by the single state register update
// a two-entry output buffer keeps in_ready high while one result waits
// reset: synchronous; door state unknown, full close idle, windows to defaults
module door_position_motor_sequencer #(
  parameter int HOME_OPEN_LEVEL = 144,
  parameter int SENSOR_BITS     = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,

  input  logic                                 cfg_en,
  input  logic [dpms_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [dpms_pkg::CFG_DATA_BITS-1:0]   cfg_data,

  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           opcode,
  input  logic [SENSOR_BITS-1:0]               sensor_value,

  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [2:0]                           door_state,
  output logic [1:0]                           motor_action,
  output logic                                 full_close_busy
);

  localparam logic [SENSOR_BITS-1:0] HOME_LEVEL = SENSOR_BITS'(HOME_OPEN_LEVEL);

  dpms_pkg::cfg_word_t   cfg_regs [dpms_pkg::CFG_REGS];
  dpms_pkg::door_state_t door_mode, door_mode_next;
  logic                  closing_fully, closing_fully_next;
  dpms_pkg::action_t     act;

  dpms_pkg::result_t     res_new, out_res, skid_res;
  logic                  skid_valid;
  logic                  push, pop;

  logic win_closed, win_half, win_open, win_detect;

  function automatic logic in_win(input logic [SENSOR_BITS-1:0] v,
                                  input dpms_pkg::cfg_word_t lo,
                                  input dpms_pkg::cfg_word_t hi);
    return (v >= SENSOR_BITS'(lo)) && (v <= SENSOR_BITS'(hi));
  endfunction

  assign win_closed = in_win(sensor_value, cfg_regs[dpms_pkg::REG_CLOSED_LOW],
                             cfg_regs[dpms_pkg::REG_CLOSED_HIGH]);
  assign win_half   = in_win(sensor_value, cfg_regs[dpms_pkg::REG_HALF_LOW],
                             cfg_regs[dpms_pkg::REG_HALF_HIGH]);
  assign win_open   = in_win(sensor_value, cfg_regs[dpms_pkg::REG_OPEN_LOW],
                             cfg_regs[dpms_pkg::REG_OPEN_HIGH]);
  assign win_detect = in_win(sensor_value, cfg_regs[dpms_pkg::REG_DETECT_LOW],
                             cfg_regs[dpms_pkg::REG_DETECT_HIGH]);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dpms_pkg::CFG_REGS; i++) begin
        cfg_regs[i] <= dpms_pkg::CFG_RESET[i];
      end
    end else if (cfg_en) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  // next state
  always_comb begin
    door_mode_next     = door_mode;
    closing_fully_next = closing_fully;
    if (closing_fully) begin
      if (opcode == dpms_pkg::OP_SAMPLE && win_closed) begin
        closing_fully_next = 1'b0;
      end
    end else begin
      unique case (opcode)
        dpms_pkg::OP_OPEN: begin
          if (door_mode == dpms_pkg::ST_UNKNOWN || door_mode == dpms_pkg::ST_CLOSED ||
              door_mode == dpms_pkg::ST_HALF) begin
            door_mode_next = dpms_pkg::ST_OPENING;
          end
        end
        dpms_pkg::OP_FULL_CLOSE: closing_fully_next = 1'b1;
        dpms_pkg::OP_SAMPLE: begin
          unique case (door_mode)
            dpms_pkg::ST_OPENING: if (win_open) door_mode_next = dpms_pkg::ST_OPEN;
            dpms_pkg::ST_OPEN:    if (win_detect) door_mode_next = dpms_pkg::ST_DETECT;
            dpms_pkg::ST_DETECT:  if (win_half) door_mode_next = dpms_pkg::ST_HALF;
            default: begin
              if (win_closed) door_mode_next = dpms_pkg::ST_CLOSED;
              else if (win_half) door_mode_next = dpms_pkg::ST_HALF;
              else if (sensor_value > HOME_LEVEL) door_mode_next = dpms_pkg::ST_HOME;
              else door_mode_next = dpms_pkg::ST_UNKNOWN;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // motor action
  always_comb begin
    act = dpms_pkg::ACT_NONE;
    if (closing_fully) begin
      if (opcode == dpms_pkg::OP_SAMPLE && win_closed) act = dpms_pkg::ACT_STOP;
    end else begin
      unique case (opcode)
        dpms_pkg::OP_OPEN: begin
          if (door_mode == dpms_pkg::ST_UNKNOWN || door_mode == dpms_pkg::ST_CLOSED ||
              door_mode == dpms_pkg::ST_HALF) begin
            act = dpms_pkg::ACT_REV;
          end
        end
        dpms_pkg::OP_FULL_CLOSE: act = dpms_pkg::ACT_FWD;
        dpms_pkg::OP_SAMPLE: begin
          unique case (door_mode)
            dpms_pkg::ST_OPENING: if (win_open) act = dpms_pkg::ACT_STOP;
            dpms_pkg::ST_OPEN:    if (win_detect) act = dpms_pkg::ACT_FWD;
            dpms_pkg::ST_DETECT:  if (win_half) act = dpms_pkg::ACT_STOP;
            default: act = dpms_pkg::ACT_NONE;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign res_new = '{door_state:      door_mode_next,
                     motor_action:    act,
                     full_close_busy: closing_fully_next};

  assign in_ready = !skid_valid;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      door_mode     <= dpms_pkg::ST_UNKNOWN;
      closing_fully <= 1'b0;
    end else if (push) begin
      door_mode     <= door_mode_next;
      closing_fully <= closing_fully_next;
    end
  end

  // two-entry result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_res <= res_new;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_res   <= res_new;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= res_new;
        skid_valid <= 1'b1;
      end
    end
  end

  assign door_state      = out_res.door_state;
  assign motor_action    = out_res.motor_action;
  assign full_close_busy = out_res.full_close_busy;

endmodule

// File: verif/door_sequence_checker.sv
// ----------------------------------------------------------------------------
// door_sequence_checker
// Watches the configuration port and both beat channels of the door position
// motor sequencer. Keeps its own copy of the windows, door state and
// full-close flag. Predicts the result of every input beat and compares
// each result beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module door_sequence_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_en,
  input  logic [dpms_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  dpms_pkg::cfg_word_t                 cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [1:0]                          opcode,
  input  logic [7:0]                          sensor_value,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [2:0]                          door_state,
  input  logic [1:0]                          motor_action,
  input  logic                                full_close_busy,
  output int                                  fault_count,
  output int                                  moves_pending
);

  localparam int HOME_LEVEL = 144;

  dpms_pkg::cfg_word_t   windows [dpms_pkg::CFG_REGS];
  dpms_pkg::door_state_t door_mode;
  logic                  closing_fully;
  dpms_pkg::result_t     expected_moves [$];

  function automatic logic in_window(logic [7:0] v, int lo);
    return (v >= windows[lo]) && (v <= windows[lo + 1]);
  endfunction

  task automatic advance_door(input logic [1:0] op, input logic [7:0] val,
                              output dpms_pkg::result_t res);
    dpms_pkg::action_t act;
    act = dpms_pkg::ACT_NONE;
    if (closing_fully) begin
      if (op == dpms_pkg::OP_SAMPLE && in_window(val, dpms_pkg::REG_CLOSED_LOW)) begin
        act = dpms_pkg::ACT_STOP;
        closing_fully = 1'b0;
      end
    end else if (op == dpms_pkg::OP_OPEN) begin
      if (door_mode == dpms_pkg::ST_UNKNOWN || door_mode == dpms_pkg::ST_CLOSED ||
          door_mode == dpms_pkg::ST_HALF) begin
        door_mode = dpms_pkg::ST_OPENING;
        act = dpms_pkg::ACT_REV;
      end
    end else if (op == dpms_pkg::OP_FULL_CLOSE) begin
      closing_fully = 1'b1;
      act = dpms_pkg::ACT_FWD;
    end else if (op == dpms_pkg::OP_SAMPLE) begin
      if (door_mode == dpms_pkg::ST_OPENING) begin
        if (in_window(val, dpms_pkg::REG_OPEN_LOW)) begin
          door_mode = dpms_pkg::ST_OPEN;
          act = dpms_pkg::ACT_STOP;
        end
      end else if (door_mode == dpms_pkg::ST_OPEN) begin
        if (in_window(val, dpms_pkg::REG_DETECT_LOW)) begin
          door_mode = dpms_pkg::ST_DETECT;
          act = dpms_pkg::ACT_FWD;
        end
      end else if (door_mode == dpms_pkg::ST_DETECT) begin
        if (in_window(val, dpms_pkg::REG_HALF_LOW)) begin
          door_mode = dpms_pkg::ST_HALF;
          act = dpms_pkg::ACT_STOP;
        end
      end else if (in_window(val, dpms_pkg::REG_CLOSED_LOW)) begin
        door_mode = dpms_pkg::ST_CLOSED;
      end else if (in_window(val, dpms_pkg::REG_HALF_LOW)) begin
        door_mode = dpms_pkg::ST_HALF;
      end else if (val > HOME_LEVEL) begin
        door_mode = dpms_pkg::ST_HOME;
      end else begin
        door_mode = dpms_pkg::ST_UNKNOWN;
      end
    end
    res.door_state      = door_mode;
    res.motor_action    = act;
    res.full_close_busy = closing_fully;
  endtask

  always @(posedge clk) begin
    dpms_pkg::result_t want;
    dpms_pkg::result_t next;
    if (rst) begin
      for (int i = 0; i < dpms_pkg::CFG_REGS; i++) windows[i] = dpms_pkg::CFG_RESET[i];
      door_mode = dpms_pkg::ST_UNKNOWN;
      closing_fully = 1'b0;
      expected_moves.delete();
      fault_count = 0;
    end else begin
      // a result beat can only belong to an earlier input beat
      if (out_valid && out_ready) begin
        if (expected_moves.size() == 0) begin
          if (fault_count < 10)
            $display("%0t: result beat with nothing outstanding: state %0d action %0d busy %0d",
                     $time, door_state, motor_action, full_close_busy);
          fault_count++;
        end else begin
          want = expected_moves.pop_front();
          if (door_state !== want.door_state || motor_action !== want.motor_action ||
              full_close_busy !== want.full_close_busy) begin
            if (fault_count < 10)
              $display("%0t: mismatch: expected state %0d action %0d busy %0d, got %0d %0d %0d",
                       $time, want.door_state, want.motor_action, want.full_close_busy,
                       door_state, motor_action, full_close_busy);
            fault_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        advance_door(opcode, sensor_value, next);
        expected_moves.push_back(next);
      end
      if (cfg_en) windows[cfg_index] = cfg_data;
    end
    moves_pending = expected_moves.size();
  end

endmodule

// File: verif/door_position_motor_sequencer_tb.sv
// ----------------------------------------------------------------------------
// door_position_motor_sequencer_tb
// Drives open, sample and full-close beats into the sequencer through a
// directed opening walk and randomized door sequences under several window
// settings and backpressure mixes; the checker predicts and compares.
// ----------------------------------------------------------------------------
module door_position_motor_sequencer_tb;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         LEG_BEATS      = 270;
  localparam int         DIRECTED_BEATS = 25;
  localparam int         WATCHDOG_LIMIT = 2000;

  logic                                clk;
  logic                                rst;
  logic                                cfg_en;
  logic [dpms_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  dpms_pkg::cfg_word_t                 cfg_data;
  logic                                in_valid;
  logic                                in_ready;
  logic [1:0]                          opcode;
  logic [7:0]                          sensor_value;
  logic                                out_valid;
  logic                                out_ready;
  logic [2:0]                          door_state;
  logic [1:0]                          motor_action;
  logic                                full_close_busy;

  int                  fault_count;
  int                  moves_pending;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  stall_cycles  = 0;
  int                  beats_sent    = 0;
  dpms_pkg::cfg_word_t win [dpms_pkg::CFG_REGS];

  door_position_motor_sequencer u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_en          (cfg_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .sensor_value    (sensor_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .door_state      (door_state),
    .motor_action    (motor_action),
    .full_close_busy (full_close_busy)
  );

  door_sequence_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_en          (cfg_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .sensor_value    (sensor_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .door_state      (door_state),
    .motor_action    (motor_action),
    .full_close_busy (full_close_busy),
    .fault_count     (fault_count),
    .moves_pending   (moves_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_en || rst) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_beat(input logic [1:0] op, input logic [7:0] val);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    sensor_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op != OP_UNUSED) beats_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (moves_pending != 0);
    @(posedge clk);
    @(posedge clk);
  endtask

  task automatic load_windows();
    for (int i = 0; i < dpms_pkg::CFG_REGS; i++) begin
      cfg_en    <= 1'b1;
      cfg_index <= i[dpms_pkg::CFG_INDEX_BITS-1:0];
      cfg_data  <= win[i];
      @(posedge clk);
    end
    cfg_en <= 1'b0;
  endtask

  function automatic logic [7:0] window_value(int lo);
    case ($urandom_range(3, 0))
      0: return win[lo];
      1: return win[lo + 1];
      default: return 8'($urandom_range(win[lo + 1], win[lo]));
    endcase
  endfunction

  function automatic logic [7:0] rand_value();
    int lo;
    lo = 2 * $urandom_range(3, 0);
    case ($urandom_range(4, 0))
      0, 1: return 8'($urandom_range(255, 0));
      2, 3: return window_value(lo);
      default: return $urandom_range(1, 0) ? win[lo] - 8'd1 : win[lo + 1] + 8'd1;
    endcase
  endfunction

  task automatic run_leg(input int target);
    int pick;
    while (beats_sent < target) begin
      pick = $urandom_range(99, 0);
      if (pick < 30) begin
        // full opening walk, then closing to half, with some noise
        send_beat(dpms_pkg::OP_OPEN, rand_value());
        repeat ($urandom_range(2, 0)) send_beat(dpms_pkg::OP_SAMPLE, rand_value());
        send_beat(dpms_pkg::OP_SAMPLE, window_value(dpms_pkg::REG_OPEN_LOW));
        send_beat(dpms_pkg::OP_SAMPLE, window_value(dpms_pkg::REG_DETECT_LOW));
        send_beat(dpms_pkg::OP_SAMPLE, window_value(dpms_pkg::REG_HALF_LOW));
      end else if (pick < 45) begin
        send_beat(dpms_pkg::OP_FULL_CLOSE, rand_value());
        repeat ($urandom_range(3, 0)) send_beat(2'($urandom_range(2, 0)), rand_value());
        send_beat(dpms_pkg::OP_SAMPLE, window_value(dpms_pkg::REG_CLOSED_LOW));
      end else if (pick < 50) begin
        send_beat(OP_UNUSED, rand_value());
      end else begin
        send_beat(2'($urandom_range(2, 0)), rand_value());
      end
    end
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_en       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    opcode       <= dpms_pkg::OP_OPEN;
    sensor_value <= '0;
    for (int i = 0; i < dpms_pkg::CFG_REGS; i++) win[i] = dpms_pkg::CFG_RESET[i];
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 20;
    recv_idle_pct = 63;

    // opening walk, classification, full close
    send_beat(dpms_pkg::OP_SAMPLE, 8'd0);
    send_beat(dpms_pkg::OP_OPEN, 8'd255);
    send_beat(dpms_pkg::OP_SAMPLE, 8'd255);
    send_beat(dpms_pkg::OP_SAMPLE, 8'd143);
    send_beat(dpms_pkg::OP_SAMPLE, 8'd138);
    send_beat(dpms_pkg::OP_SAMPLE, 8'd94);
    send_beat(dpms_pkg::OP_SAMPLE, 8'd255);
    send_beat(dpms_pkg::OP_SAMPLE, 8'd144);
    send_beat(dpms_pkg::OP_SAMPLE, 8'd145);
    send_beat(dpms_pkg::OP_SAMPLE, 8'd33);
    send_beat(dpms_pkg::OP_OPEN, 8'd0);
    send_beat(dpms_pkg::OP_OPEN, 8'd0);
    send_beat(dpms_pkg::OP_SAMPLE, 8'd142);
    send_beat(dpms_pkg::OP_OPEN, 8'd0);
    send_beat(dpms_pkg::OP_SAMPLE, 8'd141);
    send_beat(dpms_pkg::OP_SAMPLE, 8'd140);
    send_beat(dpms_pkg::OP_SAMPLE, 8'd97);
    send_beat(dpms_pkg::OP_SAMPLE, 8'd96);
    send_beat(dpms_pkg::OP_OPEN, 8'd0);
    send_beat(dpms_pkg::OP_FULL_CLOSE, 8'd0);
    send_beat(dpms_pkg::OP_OPEN, 8'd0);
    send_beat(dpms_pkg::OP_FULL_CLOSE, 8'd0);
    send_beat(dpms_pkg::OP_SAMPLE, 8'd31);
    send_beat(OP_UNUSED, 8'd34);
    send_beat(dpms_pkg::OP_SAMPLE, 8'd34);

    for (int leg = 0; leg < 6; leg++) begin
      if (leg == 2) begin
        send_idle_pct = 63;
        recv_idle_pct = 20;
      end else if (leg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (leg > 0) begin
        settle();
        case (leg)
          1: win = '{8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
          2: win = '{8'd40, 8'd20, 8'd255, 8'd0, 8'd143, 8'd142, 8'd200, 8'd100};
          3: begin
            for (int i = 0; i < dpms_pkg::CFG_REGS; i += 2) begin
              win[i]     = 8'($urandom_range(255, 0));
              win[i + 1] = 8'($urandom_range((win[i] + 20 > 255) ? 255 : win[i] + 20, win[i]));
            end
          end
          4: win = dpms_pkg::CFG_RESET;
          default: win = '{8'd0, 8'd60, 8'd50, 8'd120, 8'd200, 8'd255, 8'd180, 8'd255};
        endcase
        load_windows();
      end
      run_leg(DIRECTED_BEATS + (leg + 1) * LEG_BEATS);
    end

    settle();
    repeat (4) @(posedge clk);
    @(negedge clk);
    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
